### rtl/core/qes_pkg.sv
// Shared types and constants for the quadratic equation solver.
// No dependencies.
package qes_pkg;

  localparam int DataWidth = 32;
  localparam int FracBits  = 16;
  localparam int WideWidth = 2 * DataWidth + 4;
  localparam int SqrtWidth = DataWidth + 2;
  localparam int MagWidth  = DataWidth + 2;
  localparam int QuoWidth  = MagWidth + FracBits;

  typedef enum logic [2:0] {
    CLS_DEG_HIGH = 3'd0,
    CLS_ALL      = 3'd1,
    CLS_NONE     = 3'd2,
    CLS_LINEAR   = 3'd3,
    CLS_DOUBLE   = 3'd4,
    CLS_TWO_REAL = 3'd5,
    CLS_COMPLEX  = 3'd6
  } sol_class_t;

  // One division job: sign, numerator magnitude, divisor.
  typedef struct packed {
    logic                        neg;
    logic [MagWidth-1:0]         mag;
    logic [DataWidth:0]          den_mag;
  } div_job_t;

  // Tag carried alongside the data through the pipeline.
  typedef struct packed {
    sol_class_t                  cls;
    logic                        use_r1;
    logic                        use_r2;
  } tag_t;

endpackage

### rtl/core/qes_sqrt_stage.sv
// One stage of the restoring square root, one result bit per stage.
// Depends on qes_pkg.
module qes_sqrt_stage (
  input  logic                         clk,
  input  logic                         en,
  input  logic [5:0]                   bit_idx,
  input  logic [qes_pkg::WideWidth-1:0] rem_i,
  input  logic [qes_pkg::SqrtWidth-1:0] root_i,
  output logic [qes_pkg::WideWidth-1:0] rem_r,
  output logic [qes_pkg::SqrtWidth-1:0] root_r
);
  // rem holds d - root^2; trial adds bit b: (2*root + 2^b) * 2^b.
  logic [qes_pkg::WideWidth-1:0] trial;
  logic [qes_pkg::WideWidth-1:0] rem_nxt;
  logic [qes_pkg::SqrtWidth-1:0] root_nxt;

  always_comb begin
    trial = ((qes_pkg::WideWidth'(root_i) << 1) | (qes_pkg::WideWidth'(1) << bit_idx))
            << bit_idx;
    if (trial <= rem_i) begin
      rem_nxt  = rem_i - trial;
      root_nxt = root_i | (qes_pkg::SqrtWidth'(1) << bit_idx);
    end else begin
      rem_nxt  = rem_i;
      root_nxt = root_i;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      rem_r  <= rem_nxt;
      root_r <= root_nxt;
    end
  end
endmodule

### rtl/core/qes_div_stage.sv
// One stage of a restoring divider, one quotient bit per stage.
// Depends on qes_pkg.
module qes_div_stage (
  input  logic                         clk,
  input  logic                         en,
  input  logic [qes_pkg::DataWidth:0]  den_i,
  input  logic [qes_pkg::DataWidth+1:0] rem_i,
  input  logic [qes_pkg::QuoWidth-1:0] num_i,
  output logic [qes_pkg::DataWidth+1:0] rem_r,
  output logic [qes_pkg::QuoWidth-1:0] num_r
);
  // num shifts left, quotient bits enter at the bottom.
  logic [qes_pkg::DataWidth+2:0] sh;
  logic [qes_pkg::DataWidth+2:0] diff;

  always_comb begin
    sh   = {rem_i, num_i[qes_pkg::QuoWidth-1]};
    diff = sh - (qes_pkg::DataWidth+3)'(den_i);
  end

  always_ff @(posedge clk) begin
    if (en) begin
      if (!diff[qes_pkg::DataWidth+2]) begin
        rem_r <= diff[qes_pkg::DataWidth+1:0];
        num_r <= {num_i[qes_pkg::QuoWidth-2:0], 1'b1};
      end else begin
        rem_r <= sh[qes_pkg::DataWidth+1:0];
        num_r <= {num_i[qes_pkg::QuoWidth-2:0], 1'b0};
      end
    end
  end
endmodule

### rtl/core/qes_divider.sv
// Pipelined signed fixed-point divider with truncation and clamping.
// Depends on qes_pkg and qes_div_stage.
module qes_divider (
  input  logic                          clk,
  input  logic                          en,
  input  qes_pkg::div_job_t             job_i,
  output logic [qes_pkg::DataWidth-1:0] quo_o,
  output logic                          sat_o
);
  localparam int N = qes_pkg::QuoWidth;

  logic [qes_pkg::DataWidth+1:0] rem_s [0:N];
  logic [N-1:0]                  num_s [0:N];
  logic [qes_pkg::DataWidth:0]   den_s [0:N];
  logic                          neg_s [0:N];

  assign rem_s[0] = '0;
  assign num_s[0] = {job_i.mag, {qes_pkg::FracBits{1'b0}}};
  assign den_s[0] = job_i.den_mag;
  assign neg_s[0] = job_i.neg;

  for (genvar i = 0; i < N; i++) begin : g_st
    qes_div_stage u_st (
      .clk   (clk),
      .en    (en),
      .den_i (den_s[i]),
      .rem_i (rem_s[i]),
      .num_i (num_s[i]),
      .rem_r (rem_s[i+1]),
      .num_r (num_s[i+1])
    );
    always_ff @(posedge clk) begin
      if (en) begin
        den_s[i+1] <= den_s[i];
        neg_s[i+1] <= neg_s[i];
      end
    end
  end

  localparam logic [N-1:0] Top = N'(1) << (qes_pkg::DataWidth - 1);

  always_comb begin
    sat_o = 1'b0;
    if (!neg_s[N]) begin
      if (num_s[N] > Top - N'(1)) begin
        sat_o = 1'b1;
        quo_o = {1'b0, {(qes_pkg::DataWidth-1){1'b1}}};
      end else begin
        quo_o = num_s[N][qes_pkg::DataWidth-1:0];
      end
    end else begin
      if (num_s[N] > Top) begin
        sat_o = 1'b1;
        quo_o = {1'b1, {(qes_pkg::DataWidth-1){1'b0}}};
      end else begin
        quo_o = qes_pkg::DataWidth'(-num_s[N]);
      end
    end
  end
endmodule

### rtl/core/quadratic_equation_solver_top.sv
// Quadratic equation solver, top level: front end, discriminant, square root, dividers.
// Depends on qes_pkg, qes_sqrt_stage, qes_divider.
//
// Solves one equation per clock, fully pipelined. Each item carries degree
// and Q16.16 coefficients c0, c1, c2; the result carries a class code, two
// Q16.16 roots and a saturation flag. The pipeline holds 3 front stages
// (products, discriminant, setup), 34 square root stages (one root bit
// each), 1 numerator stage and 50 divider stages (one quotient bit each),
// plus the output register. Throughput is one item per cycle;
// a stall on the output freezes the whole pipeline, which is taken by a
// single enable, so nothing is lost or repeated. The output register
// accepts a new result while the previous one is being taken.
module quadratic_equation_solver_top (
  input  logic         clk,
  input  logic         rst_n,
  input  logic         in_tvalid,
  output logic         in_tready,
  // [1:0] degree, [33:2] coef_const, [65:34] coef_linear,
  // [97:66] coef_square, [103:98] zero
  input  logic [103:0] in_tdata,
  output logic         out_tvalid,
  input  logic         out_tready,
  // [2:0] solution_class, [34:3] root_first, [66:35] root_second,
  // [67] saturated, [71:68] zero
  output logic [71:0]  out_tdata
);
  localparam int DW = qes_pkg::DataWidth;
  localparam int WW = qes_pkg::WideWidth;
  localparam int SW = qes_pkg::SqrtWidth;
  localparam int MW = qes_pkg::MagWidth;
  localparam int NSQ = SW;
  localparam int NDV = qes_pkg::QuoWidth;
  localparam int LAT = 3 + NSQ + 1 + NDV;

  // Pipeline moves when the output slot is empty or being drained.
  logic en;
  assign en        = !out_tvalid || out_tready;
  assign in_tready = en;

  logic [LAT:0] vld_r;
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= '0;
    end else if (en) begin
      vld_r <= {vld_r[LAT-1:0], in_tvalid};
    end
  end
  assign out_tvalid = vld_r[LAT];

  // Stage 1: decode and products.
  logic [1:0]          deg;
  logic signed [DW-1:0] c0, c1, c2;
  assign deg = in_tdata[1:0];
  assign c0  = in_tdata[33:2];
  assign c1  = in_tdata[65:34];
  assign c2  = in_tdata[97:66];

  logic [DW-1:0] m0, m1, m2;
  assign m0 = c0[DW-1] ? DW'(-c0) : c0;
  assign m1 = c1[DW-1] ? DW'(-c1) : c1;
  assign m2 = c2[DW-1] ? DW'(-c2) : c2;

  logic [1:0]           s1_deg_r;
  logic signed [DW-1:0] s1_c0_r, s1_c1_r, s1_c2_r;
  logic [2*DW-1:0]      s1_bb_r, s1_ac_r;
  always_ff @(posedge clk) begin
    if (en) begin
      s1_deg_r <= deg;
      s1_c0_r  <= c0;
      s1_c1_r  <= c1;
      s1_c2_r  <= c2;
      s1_bb_r  <= m1 * m1;
      s1_ac_r  <= m0 * m2;
    end
  end

  // Stage 2: discriminant.
  logic [WW-1:0] bb_w, ac4_w, d_nxt;
  logic          ac_pos, dneg_nxt;
  always_comb begin
    bb_w   = WW'(s1_bb_r);
    ac4_w  = WW'(s1_ac_r) << 2;
    ac_pos = (s1_c0_r != 0) && (s1_c0_r[DW-1] == s1_c2_r[DW-1]);
    dneg_nxt = 1'b0;
    if (!ac_pos) begin
      d_nxt = bb_w + ac4_w;
    end else if (bb_w >= ac4_w) begin
      d_nxt = bb_w - ac4_w;
    end else begin
      d_nxt    = ac4_w - bb_w;
      dneg_nxt = 1'b1;
    end
  end

  logic [1:0]           s2_deg_r;
  logic signed [DW-1:0] s2_c0_r, s2_c1_r, s2_c2_r;
  logic [WW-1:0]        s2_d_r;
  logic                 s2_dneg_r;
  always_ff @(posedge clk) begin
    if (en) begin
      s2_deg_r  <= s1_deg_r;
      s2_c0_r   <= s1_c0_r;
      s2_c1_r   <= s1_c1_r;
      s2_c2_r   <= s1_c2_r;
      s2_d_r    <= d_nxt;
      s2_dneg_r <= dneg_nxt;
    end
  end

  // Stage 3: classify and set up divider operands.
  qes_pkg::tag_t      tag_nxt;
  logic signed [DW+1:0] n1_nxt, den_nxt;
  always_comb begin
    tag_nxt  = '{cls: qes_pkg::CLS_DEG_HIGH, use_r1: 1'b0, use_r2: 1'b0};
    n1_nxt   = '0;
    den_nxt  = (DW+2)'(1);
    priority if (s2_deg_r == 2'd3) begin
      tag_nxt.cls = qes_pkg::CLS_DEG_HIGH;
    end else if (s2_deg_r == 2'd0) begin
      tag_nxt.cls = (s2_c0_r == 0) ? qes_pkg::CLS_ALL : qes_pkg::CLS_NONE;
    end else if (s2_deg_r == 2'd1 || s2_c2_r == 0) begin
      if (s2_c1_r == 0) begin
        tag_nxt.cls = (s2_c0_r == 0) ? qes_pkg::CLS_ALL : qes_pkg::CLS_NONE;
      end else begin
        tag_nxt.cls    = qes_pkg::CLS_LINEAR;
        tag_nxt.use_r1 = 1'b1;
        n1_nxt         = -(DW+2)'(s2_c0_r);
        den_nxt        = (DW+2)'(s2_c1_r);
      end
    end else begin
      tag_nxt.use_r1 = 1'b1;
      n1_nxt         = -(DW+2)'(s2_c1_r);
      den_nxt        = (DW+2)'(s2_c2_r) <<< 1;
      if (s2_d_r == 0) begin
        tag_nxt.cls = qes_pkg::CLS_DOUBLE;
      end else if (s2_dneg_r) begin
        tag_nxt.cls    = qes_pkg::CLS_COMPLEX;
        tag_nxt.use_r2 = 1'b1;
      end else begin
        tag_nxt.cls    = qes_pkg::CLS_TWO_REAL;
        tag_nxt.use_r2 = 1'b1;
      end
    end
  end

  logic [WW-1:0]       sq_rem [0:NSQ];
  logic [SW-1:0]       sq_root [0:NSQ];
  qes_pkg::tag_t       sq_tag [0:NSQ];
  logic signed [DW+1:0] sq_n1 [0:NSQ];
  logic signed [DW+1:0] sq_den [0:NSQ];

  always_ff @(posedge clk) begin
    if (en) begin
      sq_rem[0]  <= s2_d_r;
      sq_root[0] <= '0;
      sq_tag[0]  <= tag_nxt;
      sq_n1[0]   <= n1_nxt;
      sq_den[0]  <= den_nxt;
    end
  end

  // Square root pipeline, MSB first.
  for (genvar i = 0; i < NSQ; i++) begin : g_sq
    qes_sqrt_stage u_sq (
      .clk     (clk),
      .en      (en),
      .bit_idx (6'(NSQ - 1 - i)),
      .rem_i   (sq_rem[i]),
      .root_i  (sq_root[i]),
      .rem_r   (sq_rem[i+1]),
      .root_r  (sq_root[i+1])
    );
    always_ff @(posedge clk) begin
      if (en) begin
        sq_tag[i+1] <= sq_tag[i];
        sq_n1[i+1]  <= sq_n1[i];
        sq_den[i+1] <= sq_den[i];
      end
    end
  end

  // Numerator stage.
  logic signed [DW+2:0] s_ext, na_w, nb_w;
  logic [DW:0]          dmag_w;
  qes_pkg::div_job_t    ja_nxt, jb_nxt;
  always_comb begin
    s_ext  = (DW+3)'(sq_root[NSQ]);
    if (sq_tag[NSQ].cls == qes_pkg::CLS_TWO_REAL) begin
      na_w = (DW+3)'(sq_n1[NSQ]) + s_ext;
      nb_w = (DW+3)'(sq_n1[NSQ]) - s_ext;
    end else begin
      na_w = (DW+3)'(sq_n1[NSQ]);
      nb_w = s_ext;
    end
    dmag_w = sq_den[NSQ][DW+1] ? (DW+1)'(-sq_den[NSQ]) : (DW+1)'(sq_den[NSQ]);
    ja_nxt.neg     = na_w[DW+2] ^ sq_den[NSQ][DW+1];
    ja_nxt.mag     = na_w[DW+2] ? MW'(-na_w) : MW'(na_w);
    ja_nxt.den_mag = dmag_w;
    jb_nxt.neg     = nb_w[DW+2] ^ sq_den[NSQ][DW+1];
    jb_nxt.mag     = nb_w[DW+2] ? MW'(-nb_w) : MW'(nb_w);
    jb_nxt.den_mag = dmag_w;
  end

  qes_pkg::div_job_t ja_r, jb_r;
  qes_pkg::tag_t     dv_tag [0:NDV];
  always_ff @(posedge clk) begin
    if (en) begin
      ja_r      <= ja_nxt;
      jb_r      <= jb_nxt;
      dv_tag[0] <= sq_tag[NSQ];
    end
  end
  for (genvar i = 0; i < NDV; i++) begin : g_tg
    always_ff @(posedge clk) begin
      if (en) begin
        dv_tag[i+1] <= dv_tag[i];
      end
    end
  end

  logic [DW-1:0] qa, qb;
  logic          sa, sb;
  qes_divider u_div_a (.clk(clk), .en(en), .job_i(ja_r), .quo_o(qa), .sat_o(sa));
  qes_divider u_div_b (.clk(clk), .en(en), .job_i(jb_r), .quo_o(qb), .sat_o(sb));

  // Output register.
  qes_pkg::tag_t tg;
  logic [DW-1:0] r1_w, r2_w;
  logic          sat_w;
  always_comb begin
    tg    = dv_tag[NDV];
    r1_w  = tg.use_r1 ? qa : '0;
    r2_w  = tg.use_r2 ? qb : '0;
    sat_w = (tg.use_r1 && sa) || (tg.use_r2 && sb);
  end

  logic [71:0] out_r;
  always_ff @(posedge clk) begin
    if (en) begin
      out_r <= {4'b0, sat_w, r2_w, r1_w, tg.cls};
    end
  end
  assign out_tdata = out_r;
endmodule

### bench/tb_quadratic_equation_solver_top.sv
// Testbench for quadratic_equation_solver_top: directed and random equations,
// checked against an in-bench root predictor. Depends on qes_pkg and the RTL.
module tb_quadratic_equation_solver_top;
  import qes_pkg::*;

  typedef struct packed {
    sol_class_t  cls;
    logic [31:0] r1;
    logic [31:0] r2;
    logic        sat;
  } roots_t;

  // Keeps the roots predicted for accepted equations and checks results in order.
  class root_scoreboard;
    roots_t pending[$];
    int     errors;
    int     checked;

    function automatic logic signed [31:0] qdiv(logic signed [65:0] num,
                                                logic signed [65:0] den,
                                                inout logic sat);
      logic [65:0]  nm;
      logic [65:0]  dm;
      logic [97:0]  q;
      logic         neg;
      nm  = num[65] ? -num : num;
      dm  = den[65] ? -den : den;
      neg = num[65] ^ den[65];
      q   = {32'd0, nm} << 16;
      q   = q / {32'd0, dm};
      if (!neg) begin
        if (q > 98'h7FFFFFFF) begin
          sat = 1'b1;
          return 32'h7FFFFFFF;
        end
        return q[31:0];
      end
      if (q > 98'h80000000) begin
        sat = 1'b1;
        q   = 98'h80000000;
      end
      return -q[31:0];
    endfunction

    function automatic logic [67:0] isqrt(logic [67:0] d);
      logic [67:0] r;
      logic [67:0] t;
      r = 0;
      for (int b = 33; b >= 0; b--) begin
        t = r | (68'd1 << b);
        if (t * t <= d) r = t;
      end
      return r;
    endfunction

    function void note_equation(logic [1:0] deg, logic signed [31:0] c0,
                                logic signed [31:0] c1, logic signed [31:0] c2);
      roots_t             e;
      logic signed [69:0] disc;
      logic signed [65:0] s;
      e = '{CLS_DEG_HIGH, 32'd0, 32'd0, 1'b0};
      if (deg == 2'd3) begin
        e.cls = CLS_DEG_HIGH;
      end else if (deg == 2'd0) begin
        e.cls = (c0 == 0) ? CLS_ALL : CLS_NONE;
      end else if (deg == 2'd1 || c2 == 0) begin
        if (c1 == 0) begin
          e.cls = (c0 == 0) ? CLS_ALL : CLS_NONE;
        end else begin
          e.cls = CLS_LINEAR;
          e.r1  = qdiv(-66'(c0), 66'(c1), e.sat);
        end
      end else begin
        disc = 70'(c1) * 70'(c1) - 70'sd4 * 70'(c0) * 70'(c2);
        if (disc == 0) begin
          e.cls = CLS_DOUBLE;
          e.r1  = qdiv(-66'(c1), 66'sd2 * 66'(c2), e.sat);
        end else if (disc < 0) begin
          e.cls = CLS_COMPLEX;
          s     = 66'(isqrt(68'(-disc)));
          e.r1  = qdiv(-66'(c1), 66'sd2 * 66'(c2), e.sat);
          e.r2  = qdiv(s, 66'sd2 * 66'(c2), e.sat);
        end else begin
          e.cls = CLS_TWO_REAL;
          s     = 66'(isqrt(68'(disc)));
          e.r1  = qdiv(-66'(c1) + s, 66'sd2 * 66'(c2), e.sat);
          e.r2  = qdiv(-66'(c1) - s, 66'sd2 * 66'(c2), e.sat);
        end
      end
      pending.push_back(e);
    endfunction

    function void check_roots(roots_t got);
      roots_t e;
      if (pending.size() == 0) begin
        $error("unexpected result item: class %0d", got.cls);
        errors++;
        return;
      end
      e = pending.pop_front();
      checked++;
      if (got.cls !== e.cls) begin
        $error("solution_class: expected %0d, got %0d", e.cls, got.cls);
        errors++;
      end
      if (got.r1 !== e.r1) begin
        $error("root_first: expected %h, got %h", e.r1, got.r1);
        errors++;
      end
      if (got.r2 !== e.r2) begin
        $error("root_second: expected %h, got %h", e.r2, got.r2);
        errors++;
      end
      if (got.sat !== e.sat) begin
        $error("saturated: expected %0d, got %0d", e.sat, got.sat);
        errors++;
      end
    endfunction
  endclass

  logic         clk;
  logic         rst_n;
  logic         in_tvalid;
  logic         in_tready;
  logic [103:0] in_tdata;   // degree, coef_const, coef_linear, coef_square, zero
  logic         out_tvalid;
  logic         out_tready;
  logic [71:0]  out_tdata;  // solution_class, root_first, root_second, saturated, zero

  root_scoreboard board;
  int             send_idle;   // percent of cycles the sender holds off
  int             recv_stall;  // percent of cycles the receiver stalls
  bit             stim_done;
  int             class_seen[7];

  quadratic_equation_solver_top u_top (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata)
  );

  initial begin
    clk = 1'b0;
    forever #6 clk = ~clk;
  end

  // Run limit: ~1900 items, heavy idling and stalls.
  initial begin
    #(12 * 400000);
    $display("TEST FAILED");
    $finish;
  end

  // Receiver: random stalls per phase; checks every accepted result item.
  always @(posedge clk) begin
    roots_t got;
    if (!rst_n) begin
      out_tready <= 1'b0;
    end else begin
      if (out_tvalid && out_tready) begin
        got.cls = sol_class_t'(out_tdata[2:0]);
        got.r1  = out_tdata[34:3];
        got.r2  = out_tdata[66:35];
        got.sat = out_tdata[67];
        class_seen[got.cls]++;
        board.check_roots(got);
      end
      out_tready <= ($urandom_range(99) >= recv_stall);
    end
  end

  // Offer one equation; hold it until accepted, with random idle cycles first.
  task automatic send_equation(logic [1:0] deg, logic [31:0] c0, logic [31:0] c1,
                               logic [31:0] c2);
    while ($urandom_range(99) < send_idle) begin
      in_tvalid <= 1'b0;
      @(posedge clk);
    end
    in_tvalid <= 1'b1;
    in_tdata  <= {6'd0, c2, c1, c0, deg};
    @(posedge clk);
    while (!in_tready) @(posedge clk);
    board.note_equation(deg, c0, c1, c2);
  endtask

  // Random coefficient: mostly small values, sometimes full range or extremes.
  function automatic logic [31:0] rand_coef();
    case ($urandom_range(9))
      0:       return $urandom;
      1:       return ($urandom_range(1)) ? 32'h7FFFFFFF : 32'h80000000;
      2:       return 32'd0;
      3, 4:    return 32'($signed($urandom_range(64)) - 32) <<< 16;
      default: return 32'($signed($urandom_range(2000000)) - 1000000);
    endcase
  endfunction

  // Random equation, biased toward degree 2 and toward zero discriminants.
  task automatic send_random();
    logic [1:0]         deg;
    logic signed [31:0] c0;
    logic signed [31:0] c1;
    logic signed [31:0] c2;
    int                 k;
    deg = ($urandom_range(9) < 6) ? 2'd2 : 2'($urandom_range(3));
    c0  = rand_coef();
    c1  = rand_coef();
    c2  = rand_coef();
    if ($urandom_range(7) == 0) begin
      // double root: c1 = 2k, c2 = 1, c0 = k*k in raw integer form
      k  = $signed($urandom_range(60000)) - 30000;
      c1 = 2 * k;
      c2 = 1;
      c0 = k * k;
    end
    send_equation(deg, c0, c1, c2);
  endtask

  initial begin
    rst_n     = 1'b0;
    in_tvalid = 1'b0;
    in_tdata  = '0;
    out_tready = 1'b0;
    send_idle  = 0;
    recv_stall = 0;
    stim_done  = 1'b0;
    board = new();
    repeat (7) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Directed: every class, degree extremes, coefficient extremes, saturation.
    send_equation(2'd3, 32'h12345678, 32'h1, 32'h1);
    send_equation(2'd0, 32'd0, 32'hFFFFFFFF, 32'h1);
    send_equation(2'd0, 32'h80000000, 32'd0, 32'd0);
    send_equation(2'd1, 32'd0, 32'd0, 32'h7FFFFFFF);
    send_equation(2'd1, 32'h7FFFFFFF, 32'd0, 32'd0);
    send_equation(2'd1, 32'h00030000, 32'h00020000, 32'h5);
    send_equation(2'd1, 32'h80000000, 32'h00000001, 32'd0);   // saturates high
    send_equation(2'd1, 32'h7FFFFFFF, 32'h00000001, 32'd0);   // saturates low
    send_equation(2'd2, 32'h00060000, 32'h00050000, 32'd0);   // falls back to linear
    send_equation(2'd2, 32'h00010000, 32'h00020000, 32'h00010000); // double at -1
    send_equation(2'd2, 32'hFFFA0000, 32'hFFFF0000, 32'h00010000); // roots 3, -2
    send_equation(2'd2, 32'h00050000, 32'h00020000, 32'h00010000); // -1 +- 2i
    send_equation(2'd2, 32'h80000000, 32'h80000000, 32'h80000000);
    send_equation(2'd2, 32'h7FFFFFFF, 32'h7FFFFFFF, 32'h7FFFFFFF);
    send_equation(2'd2, 32'h80000000, 32'h7FFFFFFF, 32'h00000001);
    send_equation(2'd2, 32'h7FFFFFFF, 32'h80000000, 32'hFFFFFFFF);
    send_equation(2'd2, 32'd0, 32'h80000000, 32'h00000001);
    send_equation(2'd2, 32'd0, 32'd0, 32'h80000000);
    send_equation(2'd2, 32'h00000001, 32'd0, 32'h7FFFFFFF);

    // Random phases: none, sender idle, receiver stall, both.
    for (int ph = 0; ph < 4; ph++) begin
      send_idle  = (ph == 1 || ph == 3) ? ((ph == 3) ? 21 : 73) : 0;
      recv_stall = (ph == 2 || ph == 3) ? ((ph == 3) ? 21 : 73) : 0;
      for (int i = 0; i < 460; i++) begin
        send_random();
        if (ph == 0 && i == 200) begin
          // drain the pipeline fully before continuing
          in_tvalid <= 1'b0;
          @(posedge clk);
          while (board.pending.size() != 0) @(posedge clk);
        end
      end
    end
    in_tvalid <= 1'b0;
    recv_stall = 30;
    stim_done  = 1'b1;

    while (board.pending.size() != 0) @(posedge clk);
    repeat (100) @(posedge clk);

    $display("Checked %0d result items; per class: %0d %0d %0d %0d %0d %0d %0d",
             board.checked, class_seen[0], class_seen[1], class_seen[2], class_seen[3],
             class_seen[4], class_seen[5], class_seen[6]);
    if (board.errors == 0 && board.pending.size() == 0) begin
      $display("TEST PASSED");
    end else begin
      $display("TEST FAILED");
    end
    $finish;
  end

endmodule
